/* hw/rtl/gopd_pkg.sv */
// Package for the glyph outline point decoder: phase codes, status codes,
// queue entry and result types. No dependencies.
package gopd_pkg;

    localparam logic [1:0] ST_POINT     = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_COMPOSITE = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam int COORD_W = 23;

    typedef enum logic [12:0] {
        PH_IDLE     = 13'b0000000000001,
        PH_NC_LO    = 13'b0000000000010,
        PH_BBOX     = 13'b0000000000100,
        PH_END_HI   = 13'b0000000001000,
        PH_END_LO   = 13'b0000000010000,
        PH_INS_HI   = 13'b0000000100000,
        PH_INS_LO   = 13'b0000001000000,
        PH_INS_SKIP = 13'b0000010000000,
        PH_FLAG     = 13'b0000100000000,
        PH_REPEAT   = 13'b0001000000000,
        PH_X        = 13'b0010000000000,
        PH_Y        = 13'b0100000000000,
        PH_DONE     = 13'b1000000000000
    } phase_t;

    // one input byte as it travels from the front to the back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       glyph_start;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         point_index;
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
        logic               on_path;
        logic               contour_end;
        logic               last;
    } result_t;

endpackage

/* hw/rtl/gopd_byte_queue.sv */
// Two-entry byte queue between the accepting front and the decoding back.
// Depends on gopd_pkg.
module gopd_byte_queue
    import gopd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  byte_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output byte_item_t out_item
);
    byte_item_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* hw/rtl/gopd_decoder.sv */
// Back part: parses glyph bytes, holds flag/x/end-point stores and emits point
// results via an output register, at most one per cycle. Depends on gopd_pkg.
module gopd_decoder
    import gopd_pkg::*;
#(
    parameter int MAX_POINTS   = 64,
    parameter int MAX_CONTOURS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  byte_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_res
);
    localparam int PW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_CONTOURS + 1);
    localparam int EW = (MAX_CONTOURS > 1) ? $clog2(MAX_CONTOURS) : 1;

    phase_t             phase_reg, phase_next;
    logic [7:0]         hold_reg, hold_next;
    logic               held_reg, held_next;
    logic [CW-1:0]      ctot_reg, ctot_next;
    logic [CW-1:0]      cptr_reg, cptr_next;
    logic [PW:0]        ptot_reg, ptot_next;
    logic [PW:0]        pptr_reg, pptr_next;
    logic [15:0]        skip_reg, skip_next;
    logic [7:0]         rep_reg, rep_next;
    logic               rep_act_reg, rep_act_next;
    logic [COORD_W-1:0] rx_reg, rx_next;
    logic [COORD_W-1:0] ry_reg, ry_next;
    logic [15:0]        endp_reg [MAX_CONTOURS];
    logic [5:0]         flag_mem [MAX_POINTS];
    logic [COORD_W-1:0] x_mem [MAX_POINTS];
    logic [5:0]         flag_rd_reg;
    logic [COORD_W-1:0] x_rd_reg;
    logic [5:0]         prev_flag_reg, prev_flag_next;
    result_t            res_reg, res_next;
    logic               res_valid_reg, res_valid_next;

    logic               slot_free;
    logic               take;
    logic               in_range;
    logic [PW-1:0]      pidx;
    logic [PW-1:0]      raddr;
    logic [5:0]         cur_flag;
    logic [15:0]        word;
    logic [COORD_W-1:0] delta;
    logic               have_delta;
    logic               is_end;
    logic               fwr_en, xwr_en, ewr_en;
    logic [5:0]         fwr_data;
    logic [COORD_W-1:0] xwr_data;
    logic [15:0]        ewr_data;
    logic               cascade;

    assign slot_free = !res_valid_reg || out_ready;
    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;
    assign pidx      = pptr_reg[PW-1:0];
    // stores are read through registers addressed by the next point pointer
    assign raddr     = pptr_next[PW-1:0];
    assign in_range  = (pptr_reg < ptot_reg);
    assign cur_flag  = flag_rd_reg;
    assign word      = {hold_reg, in_item.data_byte};

    // cascade steps and repeat expansion take no byte
    always_comb
    begin
        cascade = 1'b0;
        if (rep_act_reg)
        begin
            cascade = 1'b1;
        end
        else if (phase_reg == PH_X)
        begin
            cascade = !in_range || (!cur_flag[1] && cur_flag[4]);
        end
        else if (phase_reg == PH_Y)
        begin
            cascade = !in_range || (!cur_flag[2] && cur_flag[5]);
        end
    end
    assign in_ready = slot_free && !cascade;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        is_end = 1'b0;
        for (int i = 0; i < MAX_CONTOURS; i++)
        begin
            if ((CW'(i) < ctot_reg) && (endp_reg[i] == 16'(pptr_reg)))
            begin
                is_end = 1'b1;
            end
        end
    end

    always_comb
    begin
        logic sbit, pbit;
        sbit = (phase_reg == PH_X) ? cur_flag[1] : cur_flag[2];
        pbit = (phase_reg == PH_X) ? cur_flag[4] : cur_flag[5];
        have_delta = 1'b0;
        delta = '0;
        if (sbit)
        begin
            have_delta = 1'b1;
            delta = pbit ? COORD_W'(in_item.data_byte)
                         : COORD_W'(0) - COORD_W'(in_item.data_byte);
        end
        else if (held_reg)
        begin
            have_delta = 1'b1;
            delta = COORD_W'(signed'(word));
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        hold_next = hold_reg;
        held_next = held_reg;
        ctot_next = ctot_reg;
        cptr_next = cptr_reg;
        ptot_next = ptot_reg;
        pptr_next = pptr_reg;
        skip_next = skip_reg;
        rep_next = rep_reg;
        rep_act_next = rep_act_reg;
        rx_next = rx_reg;
        ry_next = ry_reg;
        prev_flag_next = prev_flag_reg;
        res_next = res_reg;
        res_valid_next = res_valid_reg && !out_ready;
        fwr_en = 1'b0; fwr_data = '0;
        xwr_en = 1'b0; xwr_data = '0;
        ewr_en = 1'b0; ewr_data = '0;

        if (rep_act_reg)
        begin
            // expand one repeated flag per cycle
            if (rep_reg != 8'd0 && in_range)
            begin
                fwr_en = 1'b1;
                fwr_data = prev_flag_reg;
                pptr_next = pptr_reg + 1'b1;
                rep_next = rep_reg - 8'd1;
            end
            else
            begin
                rep_act_next = 1'b0;
                if (!in_range)
                begin
                    phase_next = PH_X;
                    pptr_next = '0;
                    rx_next = '0;
                    held_next = 1'b0;
                end
                else
                begin
                    phase_next = PH_FLAG;
                end
            end
        end
        else if (cascade && slot_free)
        begin
            if (phase_reg == PH_X)
            begin
                if (!in_range)
                begin
                    phase_next = PH_Y;
                    pptr_next = '0;
                    ry_next = '0;
                end
                else
                begin
                    xwr_en = 1'b1;
                    xwr_data = rx_reg;
                    pptr_next = pptr_reg + 1'b1;
                end
            end
            else
            begin
                if (!in_range)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    res_next = '{ST_POINT, 6'(pptr_reg), x_rd_reg, ry_reg,
                                 cur_flag[0], is_end, (pptr_reg + 1'b1 == ptot_reg)};
                    pptr_next = pptr_reg + 1'b1;
                end
            end
        end
        else if (take)
        begin
            if (in_item.glyph_start)
            begin
                phase_next = PH_NC_LO;
                hold_next = in_item.data_byte;
                held_next = 1'b1;
                ctot_next = '0; cptr_next = '0; ptot_next = '0; pptr_next = '0;
                skip_next = '0; rep_next = '0; rx_next = '0; ry_next = '0;
            end
            else
            begin
                unique case (phase_reg) inside
                    PH_NC_LO:
                    begin
                        held_next = 1'b0;
                        res_next = '{ST_POINT, 6'd0, '0, '0, 1'b0, 1'b0, 1'b1};
                        if (word[15])
                        begin
                            res_next.status = ST_COMPOSITE;
                            res_valid_next = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else if (word == 16'd0)
                        begin
                            res_next.status = ST_EMPTY;
                            res_valid_next = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else if (word > 16'(MAX_CONTOURS))
                        begin
                            res_next.status = ST_OVERFLOW;
                            res_valid_next = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            ctot_next = CW'(word);
                            cptr_next = '0;
                            skip_next = 16'd8;
                            phase_next = PH_BBOX;
                        end
                    end
                    PH_BBOX, PH_INS_SKIP:
                    begin
                        skip_next = skip_reg - 16'd1;
                        if (skip_reg <= 16'd1)
                        begin
                            skip_next = '0;
                            phase_next = (phase_reg == PH_BBOX) ? PH_END_HI : PH_FLAG;
                        end
                    end
                    PH_END_HI, PH_INS_HI:
                    begin
                        hold_next = in_item.data_byte;
                        held_next = 1'b1;
                        phase_next = (phase_reg == PH_END_HI) ? PH_END_LO : PH_INS_LO;
                    end
                    PH_END_LO:
                    begin
                        held_next = 1'b0;
                        ewr_en = 1'b1;
                        ewr_data = word;
                        cptr_next = cptr_reg + 1'b1;
                        if (cptr_reg + 1'b1 >= ctot_reg)
                        begin
                            if ({1'b0, word} + 17'd1 > 17'(MAX_POINTS))
                            begin
                                res_next = '{ST_OVERFLOW, 6'd0, '0, '0, 1'b0, 1'b0, 1'b1};
                                res_valid_next = 1'b1;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                ptot_next = (PW + 1)'(word) + 1'b1;
                                phase_next = PH_INS_HI;
                            end
                        end
                        else
                        begin
                            phase_next = PH_END_HI;
                        end
                    end
                    PH_INS_LO:
                    begin
                        held_next = 1'b0;
                        skip_next = word;
                        pptr_next = '0;
                        phase_next = (word != 16'd0) ? PH_INS_SKIP : PH_FLAG;
                    end
                    PH_FLAG:
                    begin
                        fwr_en = 1'b1;
                        fwr_data = in_item.data_byte[5:0];
                        prev_flag_next = in_item.data_byte[5:0];
                        pptr_next = pptr_reg + 1'b1;
                        if (in_item.data_byte[3])
                        begin
                            phase_next = PH_REPEAT;
                        end
                        else if (pptr_reg + 1'b1 >= ptot_reg)
                        begin
                            phase_next = PH_X;
                            pptr_next = '0;
                            rx_next = '0;
                            held_next = 1'b0;
                        end
                    end
                    PH_REPEAT:
                    begin
                        rep_next = in_item.data_byte;
                        rep_act_next = 1'b1;
                    end
                    PH_X:
                    begin
                        if (have_delta)
                        begin
                            held_next = 1'b0;
                            rx_next = rx_reg + delta;
                            xwr_en = 1'b1;
                            xwr_data = rx_reg + delta;
                            pptr_next = pptr_reg + 1'b1;
                        end
                        else
                        begin
                            hold_next = in_item.data_byte;
                            held_next = 1'b1;
                        end
                    end
                    PH_Y:
                    begin
                        if (have_delta)
                        begin
                            held_next = 1'b0;
                            ry_next = ry_reg + delta;
                            res_valid_next = 1'b1;
                            res_next = '{ST_POINT, 6'(pptr_reg), x_rd_reg,
                                         ry_reg + delta, cur_flag[0], is_end,
                                         (pptr_reg + 1'b1 == ptot_reg)};
                            pptr_next = pptr_reg + 1'b1;
                        end
                        else
                        begin
                            hold_next = in_item.data_byte;
                            held_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fwr_en)
        begin
            flag_mem[pidx] <= fwr_data;
        end
        if (xwr_en)
        begin
            x_mem[pidx] <= xwr_data;
        end
        if (ewr_en)
        begin
            endp_reg[cptr_reg[EW-1:0]] <= ewr_data;
        end
        // pass a flag written at the address being read straight through
        flag_rd_reg <= (fwr_en && (pidx == raddr)) ? fwr_data : flag_mem[raddr];
        x_rd_reg <= x_mem[raddr];
        prev_flag_reg <= prev_flag_next;
        res_reg <= res_next;
        hold_reg <= hold_next;
        skip_reg <= skip_next;
        rep_reg <= rep_next;
        rx_reg <= rx_next;
        ry_reg <= ry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg <= 1'b0;
            ctot_reg <= '0;
            cptr_reg <= '0;
            ptot_reg <= '0;
            pptr_reg <= '0;
            rep_act_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg <= held_next;
            ctot_reg <= ctot_next;
            cptr_reg <= cptr_next;
            ptot_reg <= ptot_next;
            pptr_reg <= pptr_next;
            rep_act_reg <= rep_act_next;
            res_valid_reg <= res_valid_next;
        end
    end
endmodule

/* hw/rtl/glyph_outline_point_decoder.sv */
// Top level of the glyph outline point decoder: byte queue plus decoder.
// Depends on gopd_pkg, gopd_byte_queue and gopd_decoder.
//
// Usage: feed the bytes of a simple glyph record on s_axis, one per
// transaction, with s_axis_tuser high on the first byte (contour count high
// byte). Results leave on m_axis: one transaction per point in index order,
// or a single status transaction for empty, composite or oversized glyphs.
// m_axis_tlast marks the final result of a glyph.
// Throughput: one byte per cycle while parsing, unless the output stalls.
// No byte is taken while repeated flags are expanded or a repeat run is
// closed, for points whose delta takes no bytes, or at an x-to-y or
// y-to-done change. A byte's result sits in the output register in the
// cycle after the byte leaves the queue; between the byte's transaction
// and its result lie the queue entry and the output register.
// Reset clears the parser to wait for a glyph start; stores need no clearing.
// When m_axis_tready is low the output register holds, the decoder stalls
// and the two-entry queue fills before s_axis_tready falls.
module glyph_outline_point_decoder
    import gopd_pkg::*;
#(
    parameter int MAX_POINTS   = 64,
    parameter int MAX_CONTOURS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // glyph_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // status, point_index, x_coord, y_coord,
                                        // on_path, contour_end
    output logic        m_axis_tlast    // last
);
    byte_item_t q_in, q_out;
    logic       q_valid, q_ready;
    result_t    res;

    // hold the byte and its start mark together through the queue
    assign q_in = '{s_axis_tdata, s_axis_tuser};

    gopd_byte_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (q_in),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_out)
    );

    gopd_decoder #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_CONTOURS (MAX_CONTOURS)
    ) u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_out),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {res.contour_end, res.on_path, res.y_coord, res.x_coord,
                           res.point_index, res.status};
    assign m_axis_tlast = res.last;
endmodule
